// File: hdl/mchw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_pkg
// Shared constants, codes and types for the multi-channel health watchdog.
// ----------------------------------------------------------------------------
package mchw_pkg;

   localparam int NUM_SENSORS = 10;
   localparam int SID_W       = 4;
   localparam int SCAN_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   localparam int TIME_W   = 32;
   localparam int UPTIME_W = 23;
   localparam int MSEC_W   = 10;
   localparam int FLAGS_W  = 5;

   localparam logic [MSEC_W-1:0] MSEC_LAST = MSEC_W'(999);

   // Flag positions inside the latched health word.
   localparam int FLAG_CTRL    = 0;
   localparam int FLAG_SENSORS = 1;
   localparam int FLAG_LINK    = 2;
   localparam int FLAG_MOTORS  = 3;
   localparam int FLAG_BATTERY = 4;

   localparam logic [15:0] RST_CHECK_INTERVAL = 16'd5000;
   localparam logic [15:0] RST_SENSOR_TIMEOUT = 16'd10000;
   localparam logic [15:0] RST_LINK_TIMEOUT   = 16'd5000;
   localparam logic [15:0] RST_BATTERY_LOW    = 16'd10500;
   localparam logic [11:0] RST_TEMP_LIMIT     = 12'd800;
   localparam logic [23:0] RST_MEMORY_MIN     = 24'd10000;
   localparam logic [15:0] RST_BATTERY_LEVEL  = 16'd12000;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_SENSOR  = 2'd1,
      CMD_LINK    = 2'd2,
      CMD_BATTERY = 2'd3
   } mchw_cmd_type;

   typedef enum logic [2:0] {
      REG_CHECK_INTERVAL = 3'd0,
      REG_SENSOR_TIMEOUT = 3'd1,
      REG_LINK_TIMEOUT   = 3'd2,
      REG_BATTERY_LOW    = 3'd3,
      REG_TEMP_LIMIT     = 3'd4,
      REG_MEMORY_MIN     = 3'd5
   } mchw_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DONE
   } mchw_state_type;

   // Sensor report write toward the row of sensor cells.
   typedef struct packed {
      logic             en;
      logic [SID_W-1:0] id;
   } mchw_wr_type;

endpackage
`default_nettype wire

// File: hdl/mchw_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_cell
// One sensor slot: time stamp, seen bit and one stage of the staleness chain.
// ----------------------------------------------------------------------------
module mchw_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [mchw_pkg::TIME_W-1:0] time_ms,
   input  wire logic [15:0]                 timeout_ms,
   input  wire logic                        ok_prev,
   output logic                             ok
);

   logic [mchw_pkg::TIME_W-1:0] stamp_ff;
   logic                        seen_ff;
   logic                        ok_ff;
   logic                        ok_in;
   logic [mchw_pkg::TIME_W-1:0] age;

   assign age   = time_ms - stamp_ff;
   // A sensor that never reported can never be stale.
   assign ok_in = ok_prev && !(seen_ff && (age > {16'd0, timeout_ms}));
   assign ok    = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         ok_ff   <= 1'b1;
      end else begin
         ok_ff <= ok_in;
         if (wr_en) begin
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_ff <= time_ms;
      end
   end

endmodule
`default_nettype wire

// File: hdl/mchw_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mchw_row
// Row of sensor cells; the health result ripples one cell per cycle.
// ----------------------------------------------------------------------------
module mchw_row (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mchw_pkg::mchw_wr_type       wr,
   input  wire logic [mchw_pkg::TIME_W-1:0] time_ms,
   input  wire logic [15:0]                 timeout_ms,
   output logic                             all_ok
);

   logic [mchw_pkg::NUM_SENSORS:0] chain;

   assign chain[0] = 1'b1;

   for (genvar i = 0; i < mchw_pkg::NUM_SENSORS; i++) begin : g_cell
      mchw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr.en && (wr.id == mchw_pkg::SID_W'(i))),
         .time_ms    (time_ms),
         .timeout_ms (timeout_ms),
         .ok_prev    (chain[i]),
         .ok         (chain[i+1])
      );
   end

   assign all_ok = chain[mchw_pkg::NUM_SENSORS];

endmodule
`default_nettype wire

// File: hdl/multi_channel_health_watchdog_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_health_watchdog_core
// Event-driven health supervisor with a row of sensor cells and APB registers.
// ----------------------------------------------------------------------------
//  Channel | Ports | Contents
//  --------+-------+-------------------------------------------------------
//  req     | req_* | tuser: cmd; tdata: sensor id, battery, temp, memory
//  rsp     | rsp_* | tdata: health flags, uptime, evaluated
//  csr     | csr_* | six settings registers at byte offsets 0x00..0x14
//
//  A sensor, link or battery word goes from IDLE straight to DONE; a tick
//  passes CHECK first, and an evaluating tick then runs SCAN, set by the
//  staleness result rippling one sensor cell per cycle.
//  One word is in work at a time; a finished result waits in the output
//  register while the next word is accepted. Synchronous reset clears
//  the clock, the sensor seen bits and sets all health flags.
// ----------------------------------------------------------------------------
module multi_channel_health_watchdog_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] cmd
   input  wire logic [1:0]  req_tuser,
   // [3:0] sensor_id, [19:4] battery_mv, [31:20] temperature_tenths,
   // [55:32] free_memory_bytes
   input  wire logic [55:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] healthy, [1] controller_ok, [2] sensors_ok, [3] link_ok,
   // [4] motors_ok, [5] battery_ok, [28:6] uptime_seconds, [29] evaluated
   output logic [31:0]      rsp_tdata,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int TW = mchw_pkg::TIME_W;

   // Settings registers.
   logic [15:0]        check_interval_ff;
   logic [15:0]        sensor_timeout_ff;
   logic [15:0]        link_timeout_ff;
   logic [15:0]        battery_low_ff;
   logic signed [11:0] temp_limit_ff;
   logic [23:0]        memory_min_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   // Watchdog state.
   logic [TW-1:0]                      time_ms_ff;
   logic [TW-1:0]                      last_check_ff;
   logic [TW-1:0]                      last_link_ff;
   logic [15:0]                        battery_ff;
   logic [mchw_pkg::FLAGS_W-1:0]       flags_ff;
   logic [mchw_pkg::FLAGS_W-1:0]       flags_in;
   logic [mchw_pkg::UPTIME_W-1:0]      uptime_ff;
   logic [mchw_pkg::UPTIME_W-1:0]      sec_ff;
   logic [mchw_pkg::MSEC_W-1:0]        msec_ff;
   logic signed [11:0]                 temp_ff;
   logic [23:0]                        mem_ff;
   logic                               evaluated_ff;
   logic [mchw_pkg::SCAN_W-1:0]        cnt_ff;
   logic                               rsp_valid_ff;
   logic [31:0]                        rsp_data_ff;
   logic [31:0]                        rsp_data_in;

   mchw_pkg::mchw_state_type state_ff;
   mchw_pkg::mchw_state_type state_in;
   mchw_pkg::mchw_cmd_type   cmd;
   mchw_pkg::mchw_wr_type    row_wr;

   logic accept;
   logic eval_due;
   logic scan_last;
   logic rsp_free;
   logic load_rsp;
   logic sensors_ok;
   logic ctrl_ok;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         check_interval_ff <= mchw_pkg::RST_CHECK_INTERVAL;
         sensor_timeout_ff <= mchw_pkg::RST_SENSOR_TIMEOUT;
         link_timeout_ff   <= mchw_pkg::RST_LINK_TIMEOUT;
         battery_low_ff    <= mchw_pkg::RST_BATTERY_LOW;
         temp_limit_ff     <= mchw_pkg::RST_TEMP_LIMIT;
         memory_min_ff     <= mchw_pkg::RST_MEMORY_MIN;
      end else if (csr_write) begin
         case (csr_index)
            mchw_pkg::REG_CHECK_INTERVAL: check_interval_ff <= csr_pwdata[15:0];
            mchw_pkg::REG_SENSOR_TIMEOUT: sensor_timeout_ff <= csr_pwdata[15:0];
            mchw_pkg::REG_LINK_TIMEOUT:   link_timeout_ff   <= csr_pwdata[15:0];
            mchw_pkg::REG_BATTERY_LOW:    battery_low_ff    <= csr_pwdata[15:0];
            mchw_pkg::REG_TEMP_LIMIT:     temp_limit_ff     <= csr_pwdata[11:0];
            mchw_pkg::REG_MEMORY_MIN:     memory_min_ff     <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         mchw_pkg::REG_CHECK_INTERVAL: csr_prdata = {16'd0, check_interval_ff};
         mchw_pkg::REG_SENSOR_TIMEOUT: csr_prdata = {16'd0, sensor_timeout_ff};
         mchw_pkg::REG_LINK_TIMEOUT:   csr_prdata = {16'd0, link_timeout_ff};
         mchw_pkg::REG_BATTERY_LOW:    csr_prdata = {16'd0, battery_low_ff};
         mchw_pkg::REG_TEMP_LIMIT:     csr_prdata = {20'd0, temp_limit_ff};
         mchw_pkg::REG_MEMORY_MIN:     csr_prdata = {8'd0, memory_min_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   assign cmd       = mchw_pkg::mchw_cmd_type'(req_tuser);
   assign eval_due  = (time_ms_ff - last_check_ff) >= {16'd0, check_interval_ff};
   assign scan_last = (cnt_ff == mchw_pkg::SCAN_W'(mchw_pkg::NUM_SENSORS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mchw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (cmd == mchw_pkg::CMD_TICK) ? mchw_pkg::ST_CHECK
                                                     : mchw_pkg::ST_DONE;
            end
         end
         mchw_pkg::ST_CHECK: begin
            state_in = eval_due ? mchw_pkg::ST_SCAN : mchw_pkg::ST_DONE;
         end
         mchw_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = mchw_pkg::ST_DONE;
            end
         end
         mchw_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = mchw_pkg::ST_IDLE;
            end
         end
         default: state_in = mchw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         mchw_pkg::ST_IDLE:  req_tready = 1'b1;
         mchw_pkg::ST_CHECK: ;
         mchw_pkg::ST_SCAN:  ;
         mchw_pkg::ST_DONE:  load_rsp = rsp_free;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mchw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Sensor row
   // ------------------------------------------------------------------------
   assign row_wr.en = accept && (cmd == mchw_pkg::CMD_SENSOR);
   assign row_wr.id = req_tdata[3:0];

   mchw_row u_row (
      .clock      (clock),
      .reset      (reset),
      .wr         (row_wr),
      .time_ms    (time_ms_ff),
      .timeout_ms (sensor_timeout_ff),
      .all_ok     (sensors_ok)
   );

   // ------------------------------------------------------------------------
   // Clock, reports and evaluation
   // ------------------------------------------------------------------------
   assign ctrl_ok = (temp_ff < temp_limit_ff) && (mem_ff > memory_min_ff);

   always_comb begin
      flags_in                         = '0;
      flags_in[mchw_pkg::FLAG_CTRL]    = ctrl_ok;
      flags_in[mchw_pkg::FLAG_SENSORS] = sensors_ok;
      flags_in[mchw_pkg::FLAG_LINK]    =
         (time_ms_ff - last_link_ff) <= {16'd0, link_timeout_ff};
      flags_in[mchw_pkg::FLAG_MOTORS]  = flags_in[mchw_pkg::FLAG_LINK];
      flags_in[mchw_pkg::FLAG_BATTERY] = battery_ff > battery_low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ms_ff    <= '0;
         last_check_ff <= '0;
         last_link_ff  <= '0;
         battery_ff    <= mchw_pkg::RST_BATTERY_LEVEL;
         flags_ff      <= '1;
         uptime_ff     <= '0;
         sec_ff        <= '0;
         msec_ff       <= '0;
         evaluated_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (accept) begin
            evaluated_ff <= 1'b0;
            case (cmd)
               mchw_pkg::CMD_TICK: begin
                  time_ms_ff <= time_ms_ff + 1'b1;
                  // Seconds restart with the millisecond clock when it wraps.
                  if (time_ms_ff == '1) begin
                     msec_ff <= '0;
                     sec_ff  <= '0;
                  end else if (msec_ff == mchw_pkg::MSEC_LAST) begin
                     msec_ff <= '0;
                     sec_ff  <= sec_ff + 1'b1;
                  end else begin
                     msec_ff <= msec_ff + 1'b1;
                  end
               end
               mchw_pkg::CMD_SENSOR:  ;
               mchw_pkg::CMD_LINK:    last_link_ff <= time_ms_ff;
               mchw_pkg::CMD_BATTERY: battery_ff   <= req_tdata[19:4];
               default: ;
            endcase
         end
         if (state_ff == mchw_pkg::ST_CHECK) begin
            evaluated_ff <= eval_due;
            cnt_ff       <= '0;
         end
         if (state_ff == mchw_pkg::ST_SCAN) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (scan_last) begin
               last_check_ff <= time_ms_ff;
               uptime_ff     <= sec_ff;
               flags_ff      <= flags_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (cmd == mchw_pkg::CMD_TICK)) begin
         temp_ff <= req_tdata[31:20];
         mem_ff  <= req_tdata[55:32];
      end
   end

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_data_in       = '0;
      rsp_data_in[0]    = &flags_ff;
      rsp_data_in[5:1]  = flags_ff;
      rsp_data_in[28:6] = uptime_ff;
      rsp_data_in[29]   = evaluated_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_one_word_in_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second word accepted while one is in work");

   a_scan_only_for_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mchw_pkg::ST_CHECK) |-> $past(cmd == mchw_pkg::CMD_TICK))
      else $error("evaluation check entered for a word that is no tick");

   a_motors_follow_link: assert property (@(posedge clock) disable iff (reset)
      flags_ff[mchw_pkg::FLAG_MOTORS] == flags_ff[mchw_pkg::FLAG_LINK])
      else $error("motor flag differs from link flag");

   a_evaluated_sets_check: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && evaluated_ff) |-> (last_check_ff == time_ms_ff))
      else $error("evaluated result without updated check time");

endmodule
`default_nettype wire
